[hdl/bslpc_pkg.sv]
// Package for the button short/long press classifier.
// Holds the event record type, register codes, widths and reset thresholds.
// No dependencies.
`default_nettype none

package bslpc_pkg;

  localparam int PIN_COUNT = 4;
  localparam int IDX_W     = 2;
  localparam int TIME_W    = 64;
  localparam int CFG_W     = 16;
  localparam int THR_US_W  = 26;
  localparam int US_PER_MS = 1000;
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = 1;
  localparam int QCNT_W    = 2;

  localparam logic [CFG_W-1:0] SHORT_MIN_RST = 16'd50;
  localparam logic [CFG_W-1:0] LONG_MIN_RST  = 16'd1000;

  localparam logic [THR_US_W-1:0] SHORT_US_RST =
    THR_US_W'(SHORT_MIN_RST) * THR_US_W'(US_PER_MS);
  localparam logic [THR_US_W-1:0] LONG_US_RST =
    THR_US_W'(LONG_MIN_RST) * THR_US_W'(US_PER_MS);

  typedef enum logic {
    REG_SHORT_MIN = 1'b0,
    REG_LONG_MIN  = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    KIND_SHORT = 1'b0,
    KIND_LONG  = 1'b1
  } press_kind_t;

  typedef struct packed {
    logic [PIN_COUNT-1:0] ev_mask;
    logic [PIN_COUNT-1:0] ev_kind;
  } poll_rec_t;

  function automatic logic [IDX_W-1:0] first_bit(input logic [PIN_COUNT-1:0] m);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = PIN_COUNT - 1; i >= 0; i--) begin
      if (m[i]) begin
        idx = IDX_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

[hdl/bslpc_front.sv]
// Front part: threshold registers, per-button press state and classification.
// Turns each accepted poll that yields events into one record of events. Depends on bslpc_pkg.
`default_nettype none

module bslpc_front import bslpc_pkg::*; #(
  parameter int NUM_BUTTONS = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic                 cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  input  wire logic                 in_push,
  input  wire logic [PIN_COUNT-1:0] in_pin_levels,
  input  wire logic [TIME_W-1:0]    in_now_us,
  input  wire logic                 q_full,
  output logic                      q_push,
  output poll_rec_t                 q_rec
);

  localparam int NUM_LANES = (NUM_BUTTONS < PIN_COUNT) ? NUM_BUTTONS : PIN_COUNT;

  logic [THR_US_W-1:0]  short_us_r, short_us_nxt;
  logic [THR_US_W-1:0]  long_us_r, long_us_nxt;
  logic [THR_US_W-1:0]  cfg_us;
  logic                 accept;
  logic [PIN_COUNT-1:0] ev_mask;
  logic [PIN_COUNT-1:0] ev_kind;

  assign cfg_us = THR_US_W'(cfg_wdata) * THR_US_W'(US_PER_MS);

  always_comb begin
    short_us_nxt = short_us_r;
    long_us_nxt  = long_us_r;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_SHORT_MIN: short_us_nxt = cfg_us;
        REG_LONG_MIN:  long_us_nxt  = cfg_us;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_us_r <= SHORT_US_RST;
      long_us_r  <= LONG_US_RST;
    end else begin
      short_us_r <= short_us_nxt;
      long_us_r  <= long_us_nxt;
    end
  end

  assign accept = in_push && !q_full;

  for (genvar b = 0; b < NUM_LANES; b++) begin : g_lane
    logic              held_r, held_nxt;
    logic              done_r, done_nxt;
    logic [TIME_W-1:0] start_r, start_nxt;
    logic              down;
    logic [TIME_W-1:0] elapsed;
    logic              short_ok;
    logic              long_ok;
    logic              lane_ev;
    logic              lane_kind;

    assign down     = ~in_pin_levels[b];
    assign elapsed  = in_now_us - start_r;
    assign short_ok = elapsed >= TIME_W'(short_us_r);
    assign long_ok  = elapsed >= TIME_W'(long_us_r);

    always_comb begin
      held_nxt  = held_r;
      done_nxt  = done_r;
      start_nxt = start_r;
      lane_ev   = 1'b0;
      lane_kind = KIND_SHORT;
      if (accept) begin
        if (down && !held_r) begin
          held_nxt  = 1'b1;
          start_nxt = in_now_us;
          done_nxt  = 1'b0;
        end else if (!down && held_r) begin
          held_nxt = 1'b0;
          lane_ev  = !done_r && short_ok;
        end else if (down && held_r && !done_r && long_ok) begin
          done_nxt  = 1'b1;
          lane_ev   = 1'b1;
          lane_kind = KIND_LONG;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        held_r <= 1'b0;
        done_r <= 1'b0;
      end else begin
        held_r <= held_nxt;
        done_r <= done_nxt;
      end
    end

    always_ff @(posedge clk) begin
      start_r <= start_nxt;
    end

    assign ev_mask[b] = lane_ev;
    assign ev_kind[b] = lane_kind;
  end

  if (NUM_LANES < PIN_COUNT) begin : g_pad
    assign ev_mask[PIN_COUNT-1:NUM_LANES] = '0;
    assign ev_kind[PIN_COUNT-1:NUM_LANES] = '0;
  end

  assign q_push        = accept && (ev_mask != '0);
  assign q_rec.ev_mask = ev_mask;
  assign q_rec.ev_kind = ev_kind;

endmodule

`default_nettype wire

[hdl/bslpc_queue.sv]
// Short record queue between the front and back parts.
// Register array with read and write pointers. Depends on bslpc_pkg.
`default_nettype none

module bslpc_queue import bslpc_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  poll_rec_t  push_rec,
  output logic       full,
  input  wire logic  pop,
  output poll_rec_t  head_rec,
  output logic       empty
);

  poll_rec_t           mem [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                do_push;
  logic                do_pop;

  assign full     = cnt_r == QCNT_W'(QDEPTH);
  assign empty    = cnt_r == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_rec = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_rec;
    end
  end

endmodule

`default_nettype wire

[hdl/bslpc_back.sv]
// Back part: takes records from the queue and hands out their events one per pop.
// Holds the current record in an output register. Depends on bslpc_pkg.
`default_nettype none

module bslpc_back import bslpc_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  poll_rec_t   q_head,
  input  wire logic   q_empty,
  output logic        q_pop,
  input  wire logic   out_pop,
  output logic        out_empty,
  output logic [IDX_W-1:0] out_button_index,
  output logic        out_press_kind,
  output logic        out_last_event
);

  poll_rec_t            cur_r, cur_nxt;
  logic                 cur_valid_r, cur_valid_nxt;
  logic [IDX_W-1:0]     idx;
  logic                 is_last;
  logic                 taken;
  logic                 load;
  logic [PIN_COUNT-1:0] rest_mask;

  assign idx       = first_bit(cur_r.ev_mask);
  assign rest_mask = cur_r.ev_mask & (cur_r.ev_mask - PIN_COUNT'(1));
  assign is_last   = rest_mask == '0;
  assign taken     = out_pop && cur_valid_r;
  assign load      = !cur_valid_r || (taken && is_last);
  assign q_pop     = load && !q_empty;

  always_comb begin
    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    if (load) begin
      cur_nxt       = q_head;
      cur_valid_nxt = !q_empty;
    end else if (taken) begin
      cur_nxt.ev_mask = rest_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  assign out_empty        = !cur_valid_r;
  assign out_button_index = idx;
  assign out_press_kind   = cur_r.ev_kind[idx];
  assign out_last_event   = is_last;

`ifndef SYNTHESIS
  a_cur_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> (cur_r.ev_mask != '0))
    else $error("current record holds no event");

  a_more_after_nonlast: assert property (@(posedge clk) disable iff (!rst_n)
    (taken && !is_last) |=> !out_empty)
    else $error("events of a record dropped");

  a_kind_in_mask: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop) |=> ((cur_r.ev_kind & ~cur_r.ev_mask) == '0))
    else $error("long flag set without event");

  a_no_pop_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_valid_r && !out_pop) |-> !q_pop)
    else $error("record loaded over a pending one");
`endif

endmodule

`default_nettype wire

[hdl/button_short_long_press_classifier_top.sv]
// Top level of the button short/long press classifier.
// Instantiates bslpc_front, bslpc_queue and bslpc_back; depends on bslpc_pkg.
`default_nettype none

// A poll is taken whenever in_full is low, so polls may arrive
// back to back; the front classifies every button in that cycle and queues one
// record of events when any event fires. The first event of a poll reaches the
// result ports after it passes the record queue and the back's output register,
// and the back hands out one event per cycle while out_pop is high; a poll holds
// at most four events. A two-entry record queue sits between the sides; in_full
// rises only when both entries and the output register are occupied.
module button_short_long_press_classifier_top import bslpc_pkg::*; #(
  parameter int NUM_BUTTONS = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic                 cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  input  wire logic                 in_push,
  output logic                      in_full,
  input  wire logic [PIN_COUNT-1:0] in_pin_levels,
  input  wire logic [TIME_W-1:0]    in_now_us,
  output logic                      out_empty,
  input  wire logic                 out_pop,
  output logic [IDX_W-1:0]          out_button_index,
  output logic                      out_press_kind,
  output logic                      out_last_event
);

  logic      q_push;
  logic      q_full;
  logic      q_pop;
  logic      q_empty;
  poll_rec_t q_in_rec;
  poll_rec_t q_head_rec;

  assign in_full = q_full;

  bslpc_front #(
    .NUM_BUTTONS(NUM_BUTTONS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_push      (in_push),
    .in_pin_levels(in_pin_levels),
    .in_now_us    (in_now_us),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_rec        (q_in_rec)
  );

  bslpc_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_rec(q_in_rec),
    .full    (q_full),
    .pop     (q_pop),
    .head_rec(q_head_rec),
    .empty   (q_empty)
  );

  bslpc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_head          (q_head_rec),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .out_pop         (out_pop),
    .out_empty       (out_empty),
    .out_button_index(out_button_index),
    .out_press_kind  (out_press_kind),
    .out_last_event  (out_last_event)
  );

endmodule

`default_nettype wire

[dv/tb_top.sv]
// Self-checking testbench for button_short_long_press_classifier_top.
// Drives polls from a directed table and random sequences, predicts press events in-line
// and checks each popped item against them. Depends on bslpc_pkg and the RTL in hdl/.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bslpc_pkg::*;

  localparam int CYCLE_LIMIT     = 200_000;
  localparam int SETTLE_CYCLES   = 10;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int ITEMS_PER_PHASE = 48;
  localparam int NUM_PHASES      = 6;
  localparam int NUM_DIRECTED    = 26;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    press_kind_t      kind;
    logic             is_last;
  } press_ev_t;

  // evs holds typed events, entry 0 in the lowest nibble: {idx, kind, is_last}
  typedef struct packed {
    logic                 is_cfg;
    logic [PIN_COUNT-1:0] pins;
    logic [TIME_W-1:0]    poll_us;
    logic [CFG_W-1:0]     cfg_short;
    logic [CFG_W-1:0]     cfg_long;
    logic                 typed;
    logic [2:0]           n_ev;
    press_ev_t [3:0]      evs;
  } dir_row_t;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  localparam dir_row_t DIRECTED_ROWS [0:NUM_DIRECTED-1] = '{
    '{1'b0, 4'hF, 64'd0,                   16'd0,     16'd0,     1'b1, 3'd0, 16'h0000},
    '{1'b0, 4'hE, 64'd1000,                16'd0,     16'd0,     1'b1, 3'd0, 16'h0000},
    '{1'b0, 4'hF, 64'd50999,               16'd0,     16'd0,     1'b1, 3'd0, 16'h0000},
    '{1'b0, 4'hE, 64'd100000,              16'd0,     16'd0,     1'b1, 3'd0, 16'h0000},
    '{1'b0, 4'hF, 64'd150000,              16'd0,     16'd0,     1'b1, 3'd1, 16'h0001},
    '{1'b0, 4'h0, 64'd200000,              16'd0,     16'd0,     1'b1, 3'd0, 16'h0000},
    '{1'b0, 4'h0, 64'd1199999,             16'd0,     16'd0,     1'b1, 3'd0, 16'h0000},
    '{1'b0, 4'h0, 64'd1200000,             16'd0,     16'd0,     1'b1, 3'd4, 16'hFA62},
    '{1'b0, 4'h0, 64'd5000000,             16'd0,     16'd0,     1'b0, 3'd0, 16'h0000},
    '{1'b0, 4'hF, 64'd6000000,             16'd0,     16'd0,     1'b1, 3'd0, 16'h0000},
    '{1'b0, 4'h7, 64'd6000000,             16'd0,     16'd0,     1'b0, 3'd0, 16'h0000},
    '{1'b0, 4'h7, 64'd2,                   16'd0,     16'd0,     1'b1, 3'd1, 16'h000F},
    '{1'b0, 4'hB, 64'hFFFF_FFFF_FFFF_FC18, 16'd0,     16'd0,     1'b0, 3'd0, 16'h0000},
    '{1'b0, 4'hF, 64'd49000,               16'd0,     16'd0,     1'b0, 3'd0, 16'h0000},
    '{1'b0, 4'hD, 64'd0,                   16'd0,     16'd0,     1'b0, 3'd0, 16'h0000},
    '{1'b0, 4'hD, 64'h0000_0100_0000_0000, 16'd0,     16'd0,     1'b1, 3'd1, 16'h0007},
    '{1'b1, 4'hF, 64'd0,                   16'd0,     16'd0,     1'b0, 3'd0, 16'h0000},
    '{1'b0, 4'hE, 64'd10,                  16'd0,     16'd0,     1'b1, 3'd0, 16'h0000},
    '{1'b0, 4'hE, 64'd10,                  16'd0,     16'd0,     1'b1, 3'd1, 16'h0003},
    '{1'b0, 4'hC, 64'd10,                  16'd0,     16'd0,     1'b0, 3'd0, 16'h0000},
    '{1'b0, 4'hF, 64'd11,                  16'd0,     16'd0,     1'b1, 3'd1, 16'h0005},
    '{1'b1, 4'hF, 64'd0,                   16'd65535, 16'd65535, 1'b0, 3'd0, 16'h0000},
    '{1'b0, 4'h0, 64'd0,                   16'd0,     16'd0,     1'b0, 3'd0, 16'h0000},
    '{1'b0, 4'h0, 64'd65534999,            16'd0,     16'd0,     1'b1, 3'd0, 16'h0000},
    '{1'b0, 4'h6, 64'd65535000,            16'd0,     16'd0,     1'b0, 3'd0, 16'h0000},
    '{1'b0, 4'hF, 64'd65535000,            16'd0,     16'd0,     1'b0, 3'd0, 16'h0000}
  };

  logic                 clk           = 1'b0;
  logic                 rst_n         = 1'b0;
  logic                 cfg_we        = 1'b0;
  cfg_reg_t             cfg_index     = REG_SHORT_MIN;
  logic [CFG_W-1:0]     cfg_wdata     = '0;
  logic                 in_push       = 1'b0;
  logic [PIN_COUNT-1:0] in_pin_levels = '1;
  logic [TIME_W-1:0]    in_now_us     = '0;
  logic                 out_pop       = 1'b0;
  logic                 in_full;
  logic                 out_empty;
  logic [IDX_W-1:0]     out_button_index;
  logic                 out_press_kind;
  logic                 out_last_event;

  logic [CFG_W-1:0]     short_min_ms;
  logic [CFG_W-1:0]     long_min_ms;
  logic [PIN_COUNT-1:0] btn_held;
  logic [PIN_COUNT-1:0] btn_long_done;
  logic [TIME_W-1:0]    btn_start [PIN_COUNT];

  press_ev_t poll_events[$];
  press_ev_t expected_events[$];

  int errors         = 0;
  int cycles         = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_trips     = 0;
  int hold_seen      = 0;
  int hold_left      = 0;

  button_short_long_press_classifier_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_pin_levels    (in_pin_levels),
    .in_now_us        (in_now_us),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_button_index (out_button_index),
    .out_press_kind   (out_press_kind),
    .out_last_event   (out_last_event)
  );

  always #5ns clk = ~clk;

  function automatic void classify_poll(input logic [PIN_COUNT-1:0] pins,
                                        input logic [TIME_W-1:0] poll_us);
    logic              down;
    logic              fire;
    press_kind_t       kind;
    logic [TIME_W-1:0] held_ms;
    poll_events.delete();
    for (int b = 0; b < PIN_COUNT; b++) begin
      down    = ~pins[b];
      fire    = 1'b0;
      kind    = KIND_SHORT;
      held_ms = (poll_us - btn_start[b]) / TIME_W'(US_PER_MS);
      if (down && !btn_held[b]) begin
        btn_held[b]      = 1'b1;
        btn_start[b]     = poll_us;
        btn_long_done[b] = 1'b0;
      end else if (!down && btn_held[b]) begin
        btn_held[b] = 1'b0;
        fire = !btn_long_done[b] && (held_ms >= TIME_W'(short_min_ms));
      end else if (down && btn_held[b] && !btn_long_done[b]) begin
        if (held_ms >= TIME_W'(long_min_ms)) begin
          btn_long_done[b] = 1'b1;
          kind = KIND_LONG;
          fire = 1'b1;
        end
      end
      if (fire) begin
        poll_events.push_back('{idx: IDX_W'(b), kind: kind, is_last: 1'b0});
      end
    end
    if (poll_events.size() > 0) begin
      poll_events[poll_events.size()-1].is_last = 1'b1;
    end
  endfunction

  task automatic deliver_poll(input logic [PIN_COUNT-1:0] pins, input logic [TIME_W-1:0] poll_us,
                              input logic typed, input logic [2:0] n_ev,
                              input press_ev_t [3:0] evs);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push       <= 1'b1;
    in_pin_levels <= pins;
    in_now_us     <= poll_us;
    do @(posedge clk); while (in_full);
    classify_poll(pins, poll_us);
    if (typed) begin
      for (int k = 0; k < n_ev; k++) expected_events.push_back(evs[k]);
    end else begin
      foreach (poll_events[k]) expected_events.push_back(poll_events[k]);
    end
  endtask

  task automatic wait_drained(input int settle);
    @(negedge clk);
    in_push <= 1'b0;
    while (expected_events.size() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic program_thresholds(input logic [CFG_W-1:0] s_ms, input logic [CFG_W-1:0] l_ms);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SHORT_MIN;
    cfg_wdata <= s_ms;
    @(negedge clk);
    cfg_index <= REG_LONG_MIN;
    cfg_wdata <= l_ms;
    @(negedge clk);
    cfg_we <= 1'b0;
    short_min_ms = s_ms;
    long_min_ms  = l_ms;
  endtask

  always @(negedge clk) begin
    if (hold_seen != hold_trips) begin
      hold_seen = hold_trips;
      hold_left = HOLD_OFF_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_pop <= 1'b0;
    end else begin
      out_pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : check_events
    press_ev_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (expected_events.size() == 0) begin
        $error("unexpected event: button_index %0d press_kind %0d last_event %0d",
               out_button_index, out_press_kind, out_last_event);
        errors++;
      end else begin
        want = expected_events.pop_front();
        if (out_button_index !== want.idx) begin
          $error("button_index: expected %0d, got %0d", want.idx, out_button_index);
          errors++;
        end
        if (out_press_kind !== want.kind) begin
          $error("press_kind: expected %0d, got %0d", want.kind, out_press_kind);
          errors++;
        end
        if (out_last_event !== want.is_last) begin
          $error("last_event: expected %0d, got %0d", want.is_last, out_last_event);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    logic [PIN_COUNT-1:0] poll_pins;
    logic [TIME_W-1:0]    poll_time;
    logic [CFG_W-1:0]     s_ms;
    logic [CFG_W-1:0]     l_ms;
    idle_mode_t           mode;
    int                   span;
    short_min_ms  = SHORT_MIN_RST;
    long_min_ms   = LONG_MIN_RST;
    btn_held      = '0;
    btn_long_done = '0;
    foreach (btn_start[b]) btn_start[b] = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < NUM_DIRECTED; r++) begin
      if (DIRECTED_ROWS[r].is_cfg) begin
        wait_drained(SETTLE_CYCLES);
        program_thresholds(DIRECTED_ROWS[r].cfg_short, DIRECTED_ROWS[r].cfg_long);
      end else begin
        deliver_poll(DIRECTED_ROWS[r].pins, DIRECTED_ROWS[r].poll_us, DIRECTED_ROWS[r].typed,
                     DIRECTED_ROWS[r].n_ev, DIRECTED_ROWS[r].evs);
      end
    end

    poll_pins = '1;
    poll_time = 64'd65535000;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_drained(SETTLE_CYCLES);
      case (ph)
        0: begin s_ms = 16'd50;    l_ms = 16'd1000;  mode = IDLE_NONE;     end
        1: begin s_ms = 16'd0;     l_ms = 16'd65535; mode = IDLE_SENDER;   end
        2: begin s_ms = 16'd65535; l_ms = 16'd0;     mode = IDLE_RECEIVER; end
        3: begin
          s_ms = CFG_W'($urandom_range(300));
          l_ms = CFG_W'($urandom_range(600));
          mode = IDLE_BOTH;
        end
        4: begin
          s_ms = CFG_W'($urandom_range(65535));
          l_ms = CFG_W'($urandom_range(65535));
          mode = IDLE_NONE;
        end
        default: begin s_ms = 16'd50; l_ms = 16'd1000; mode = IDLE_BOTH; end
      endcase
      program_thresholds(s_ms, l_ms);
      case (mode)
        IDLE_SENDER:   begin send_idle_pct = 59; recv_stall_pct = 0;  end
        IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 59; end
        IDLE_BOTH:     begin send_idle_pct = 25; recv_stall_pct = 25; end
        default:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      endcase
      span = ((s_ms > l_ms ? int'(s_ms) : int'(l_ms)) + 1) * 750;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(9) == 0) begin
          poll_pins = PIN_COUNT'($urandom);
          poll_time = {$urandom, $urandom};
        end else begin
          for (int b = 0; b < PIN_COUNT; b++) begin
            if ($urandom_range(99) < 35) poll_pins[b] = ~poll_pins[b];
          end
          poll_time = poll_time + TIME_W'($urandom_range(span));
        end
        deliver_poll(poll_pins, poll_time, 1'b0, 3'd0, '0);
        if (ph == 4 && n == 10) hold_trips++;
        if (ph == 5 && n == 20) wait_drained(0);
      end
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    wait_drained(20);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
hdl/bslpc_pkg.sv
hdl/bslpc_front.sv
hdl/bslpc_queue.sv
hdl/bslpc_back.sv
hdl/button_short_long_press_classifier_top.sv
dv/tb_top.sv
